// ----- src/csma_pkg.sv -----
// ----------------------------------------------------------------------------
// csma_pkg: shared definitions of the CSMA/CD transmit unit
// Field widths, register indexes, event codes, phase and sequencer codes and
// the request and response groups of the shift-add multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package csma_pkg;

    // Field widths
    localparam int FRAME_W  = 16;
    localparam int ATT_W    = 4;
    localparam int MSG_W    = 8;
    localparam int SLOT_W   = 8;
    localparam int OTHERS_W = 4;
    localparam int DRAW_W   = 16;
    localparam int EV_W     = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Multiplier operand widths: the second operand holds c, then c * slot + 1
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 12;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    // Reset values of the registers and the saturation value of the attempt count
    localparam logic [FRAME_W-1:0] FRAME_RST = 16'd1024;
    localparam logic [ATT_W-1:0]   MAXATT_RST = 4'd5;
    localparam logic [MSG_W-1:0]   MSGS_RST = 8'd2;
    localparam logic [SLOT_W-1:0]  SLOT_RST = 8'd4;
    localparam logic [ATT_W-1:0]   ATT_SAT = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BYTES   = 3'd0,
        CFG_MAX_ATTEMPTS  = 3'd1,
        CFG_MESSAGE_COUNT = 3'd2,
        CFG_SLOT_TICKS    = 3'd3
    } cfg_idx_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 3'd0,
        EV_START = 3'd1,
        EV_COLL  = 3'd2,
        EV_OK    = 3'd3,
        EV_ABORT = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PH_SENSE   = 2'd0,
        PH_TX      = 2'd1,
        PH_BACKOFF = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_SPAN = 2'd1,
        SQ_DRAW = 2'd2
    } seq_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] product;
    } mul_rsp_t;

endpackage

`default_nettype wire

// ----- src/csma_if.sv -----
// ----------------------------------------------------------------------------
// csma_if: handshake channels of the CSMA/CD transmit unit
// Tick word in, result word out and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface csma_item_if;
    logic                               valid;
    logic                               ready;
    logic [csma_pkg::OTHERS_W-1:0]      others_active;
    logic [csma_pkg::DRAW_W-1:0]        random_draw;

    modport source (output valid, output others_active, output random_draw, input ready);
    modport sink   (input valid, input others_active, input random_draw, output ready);
endinterface

interface csma_result_if;
    logic                               valid;
    logic                               ready;
    logic                               tx_active;
    logic [csma_pkg::EV_W-1:0]          event_res;
    logic [csma_pkg::ATT_W-1:0]         attempt_number;
    logic [csma_pkg::MSG_W-1:0]         messages_left;
    logic                               all_done;

    modport source (output valid, output tx_active, output event_res,
                    output attempt_number, output messages_left, output all_done,
                    input ready);
    modport sink   (input valid, input tx_active, input event_res,
                    input attempt_number, input messages_left, input all_done,
                    output ready);
endinterface

interface csma_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [csma_pkg::CFG_IDX_W-1:0]     index;
    logic [csma_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/csma_cd_station_transmit_unit.sv -----
// ----------------------------------------------------------------------------
// csma_cd_station_transmit_unit: CSMA/CD transmitting station
// Carrier sense, frame transmission, collision detection and random backoff,
// one medium tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one word per medium tick, carrying others_active and random_draw.
//   result : exactly one word per tick: tx_active, event_res, attempt_number,
//            messages_left and all_done.
//   cfg    : register writes (0 frame_bytes, 1 max_attempts, 2 message_count,
//            3 slot_ticks); always ready. A write of message_count also loads
//            the count of messages left. Write only while the block is idle.
// Latency and throughput:
//   A tick is evaluated at the edge that accepts it and its result word is
//   valid in the next cycle, so ordinary ticks go through at one per cycle
//   while the receiver takes each result word. A tick that ends in a collision
//   with backoff runs the shared shift-add multiplier twice, first for
//   c * slot_ticks and then for the draw times c * slot_ticks + 1; item.ready
//   stays low after such a tick until both passes are done.
// Reset: registers take their default values, the station senses the medium
//   and the number of messages left is two.
// Stall: while a result word is held by a stalled receiver a new tick is
//   accepted only in the cycle in which the held word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module csma_cd_station_transmit_unit
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    csma_item_if.sink     item,
    csma_result_if.source result,
    csma_cfg_if.sink      cfg
);

    // Configuration registers
    logic [csma_pkg::FRAME_W-1:0] frame_reg;
    logic [csma_pkg::ATT_W-1:0]   maxatt_reg;
    logic [csma_pkg::SLOT_W-1:0]  slot_reg;

    // Station state
    csma_pkg::phase_t             phase_reg, phase_next;
    logic [csma_pkg::FRAME_W-1:0] byte_reg, byte_next;
    logic [csma_pkg::OTHERS_W-1:0] coll_reg, coll_next;
    logic [csma_pkg::ATT_W-1:0]   att_reg, att_next;
    logic [csma_pkg::MSG_W-1:0]   rem_reg, rem_next;
    logic [csma_pkg::FRAME_W-1:0] backoff_reg, backoff_next;
    logic [csma_pkg::DRAW_W-1:0]  draw_reg;

    // Sequencer
    csma_pkg::seq_t               seq_reg, seq_next;

    // Result register
    logic                         out_valid_reg;
    logic                         out_tx_reg;
    csma_pkg::event_t             out_ev_reg;
    logic [csma_pkg::ATT_W-1:0]   out_att_reg;
    logic [csma_pkg::MSG_W-1:0]   out_rem_reg;

    // Tick evaluation
    logic                         tx_c;
    csma_pkg::event_t             ev_c;
    logic [csma_pkg::ATT_W-1:0]   shown_c;
    logic [csma_pkg::OTHERS_W-1:0] coll_hit_c;
    logic [csma_pkg::ATT_W-1:0]   att_inc_c;
    logic [csma_pkg::FRAME_W-1:0] byte_inc_c;
    logic                         need_bo_c;
    logic                         accept;
    logic                         cfg_wr;

    // Multiplier interface
    csma_pkg::mul_req_t           mul_req;
    csma_pkg::mul_rsp_t           mul_rsp;
    logic [csma_pkg::FRAME_W-1:0] bo_len_c;

    csma_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign accept = item.valid && item.ready;
    assign cfg_wr = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    // Next state of the station for the tick on the item channel.
    always_comb
    begin
        tx_c         = 1'b0;
        ev_c         = csma_pkg::EV_NONE;
        phase_next   = phase_reg;
        byte_next    = byte_reg;
        coll_next    = coll_reg;
        att_next     = att_reg;
        rem_next     = rem_reg;
        backoff_next = backoff_reg;
        need_bo_c    = 1'b0;
        coll_hit_c   = coll_reg;
        byte_inc_c   = byte_reg + 1'b1;
        att_inc_c    = (att_reg < csma_pkg::ATT_SAT) ? att_reg + 1'b1 : att_reg;
        shown_c      = att_reg;
        case (phase_reg)
            csma_pkg::PH_TX:
            begin
                tx_c = 1'b1;
                if (item.others_active != '0 && coll_reg == '0)
                begin
                    coll_hit_c = item.others_active;
                end
                coll_next = coll_hit_c;
                byte_next = byte_inc_c;
                if (byte_inc_c >= frame_reg || byte_inc_c == '0)
                begin
                    byte_next = '0;
                    coll_next = '0;
                    if (coll_hit_c != '0)
                    begin
                        if (att_inc_c < maxatt_reg)
                        begin
                            ev_c       = csma_pkg::EV_COLL;
                            att_next   = att_inc_c;
                            phase_next = csma_pkg::PH_BACKOFF;
                            need_bo_c  = 1'b1;
                        end
                        else
                        begin
                            ev_c       = csma_pkg::EV_ABORT;
                            att_next   = '0;
                            rem_next   = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
                            phase_next = csma_pkg::PH_SENSE;
                        end
                    end
                    else
                    begin
                        ev_c       = csma_pkg::EV_OK;
                        att_next   = '0;
                        rem_next   = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
                        phase_next = csma_pkg::PH_SENSE;
                    end
                end
            end
            csma_pkg::PH_BACKOFF:
            begin
                backoff_next = (backoff_reg != '0) ? backoff_reg - 1'b1 : backoff_reg;
                if (backoff_next == '0)
                begin
                    phase_next = csma_pkg::PH_SENSE;
                end
            end
            default:
            begin
                phase_next = csma_pkg::PH_SENSE;
                if (rem_reg != '0 && item.others_active == '0)
                begin
                    tx_c       = 1'b1;
                    ev_c       = csma_pkg::EV_START;
                    byte_next  = '0;
                    coll_next  = '0;
                    phase_next = csma_pkg::PH_TX;
                end
            end
        endcase
        // The abort word shows the count that was reached before clearing.
        shown_c = (ev_c == csma_pkg::EV_ABORT) ? att_inc_c : att_next;
    end

    // Sequencer next state.
    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            csma_pkg::SQ_IDLE:
            begin
                if (accept && need_bo_c)
                begin
                    seq_next = csma_pkg::SQ_SPAN;
                end
            end
            csma_pkg::SQ_SPAN:
            begin
                if (mul_rsp.done)
                begin
                    seq_next = csma_pkg::SQ_DRAW;
                end
            end
            csma_pkg::SQ_DRAW:
            begin
                if (mul_rsp.done)
                begin
                    seq_next = csma_pkg::SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = csma_pkg::SQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs: handshake and multiplier requests.
    always_comb
    begin
        item.ready    = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = csma_pkg::MUL_A_W'(slot_reg);
        mul_req.b     = csma_pkg::MUL_B_W'(coll_hit_c);
        case (seq_reg)
            csma_pkg::SQ_IDLE:
            begin
                item.ready    = !out_valid_reg || result.ready;
                mul_req.start = accept && need_bo_c;
            end
            csma_pkg::SQ_SPAN:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = draw_reg;
                mul_req.b     = mul_rsp.product[csma_pkg::MUL_B_W-1:0] + 1'b1;
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // Backoff length: slot plus the upper bits of draw times span.
    assign bo_len_c = csma_pkg::FRAME_W'(slot_reg)
                    + csma_pkg::FRAME_W'(mul_rsp.product[csma_pkg::MUL_P_W-1:csma_pkg::DRAW_W]);

    // Configuration, station state and sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= csma_pkg::FRAME_RST;
            maxatt_reg  <= csma_pkg::MAXATT_RST;
            slot_reg    <= csma_pkg::SLOT_RST;
            phase_reg   <= csma_pkg::PH_SENSE;
            byte_reg    <= '0;
            coll_reg    <= '0;
            att_reg     <= '0;
            rem_reg     <= csma_pkg::MSGS_RST;
            backoff_reg <= '0;
            seq_reg     <= csma_pkg::SQ_IDLE;
        end
        else
        begin
            seq_reg <= seq_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                byte_reg    <= byte_next;
                coll_reg    <= coll_next;
                att_reg     <= att_next;
                rem_reg     <= rem_next;
                backoff_reg <= backoff_next;
            end
            else if (seq_reg == csma_pkg::SQ_DRAW && mul_rsp.done)
            begin
                backoff_reg <= bo_len_c;
            end
            if (cfg_wr)
            begin
                case (csma_pkg::cfg_idx_t'(cfg.index))
                    csma_pkg::CFG_FRAME_BYTES:
                    begin
                        frame_reg <= cfg.data;
                    end
                    csma_pkg::CFG_MAX_ATTEMPTS:
                    begin
                        maxatt_reg <= cfg.data[csma_pkg::ATT_W-1:0];
                    end
                    csma_pkg::CFG_MESSAGE_COUNT:
                    begin
                        rem_reg <= cfg.data[csma_pkg::MSG_W-1:0];
                    end
                    csma_pkg::CFG_SLOT_TICKS:
                    begin
                        slot_reg <= cfg.data[csma_pkg::SLOT_W-1:0];
                    end
                    default:
                    begin
                        frame_reg <= frame_reg;
                    end
                endcase
            end
        end
    end

    // The draw is kept for the second multiplier pass.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            draw_reg <= item.random_draw;
        end
    end

    // Result word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result word payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_tx_reg  <= tx_c;
            out_ev_reg  <= ev_c;
            out_att_reg <= shown_c;
            out_rem_reg <= rem_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.tx_active      = out_tx_reg;
    assign result.event_res      = out_ev_reg;
    assign result.attempt_number = out_att_reg;
    assign result.messages_left  = out_rem_reg;
    assign result.all_done       = (out_rem_reg == '0);

`ifndef SYNTHESIS
    // The multiplier only runs while the station is in backoff.
    a_seq_backoff: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != csma_pkg::SQ_IDLE) |-> (phase_reg == csma_pkg::PH_BACKOFF))
        else $error("backoff computation outside the backoff phase");

    // Every accepted tick yields a result word in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted tick produced no result word");

    // No new tick is taken while the backoff length is being computed.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != csma_pkg::SQ_IDLE) |-> !item.ready)
        else $error("tick accepted during backoff computation");

    // A collision word always starts the multiplier sequence.
    a_coll_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ev_c == csma_pkg::EV_COLL) |=> (seq_reg == csma_pkg::SQ_SPAN))
        else $error("collision without backoff computation");
`endif

endmodule

`default_nettype wire

// ----- src/csma_mul.sv -----
// ----------------------------------------------------------------------------
// csma_mul: shift-add multiplier
// Takes one bit of the second operand per cycle; the product is ready with
// a done pulse once all MUL_B_W bits have been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module csma_mul
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire csma_pkg::mul_req_t  req,
    output csma_pkg::mul_rsp_t       rsp
);

    logic [csma_pkg::MUL_P_W-1:0]   acc_reg;
    logic [csma_pkg::MUL_P_W-1:0]   a_reg;
    logic [csma_pkg::MUL_B_W-1:0]   b_reg;
    logic [csma_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                           done_reg;

    // Iteration count and done flag are control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= csma_pkg::MUL_CNT_W'(csma_pkg::MUL_B_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == csma_pkg::MUL_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // One partial product is added per cycle while the operand shifts along.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= csma_pkg::MUL_P_W'(req.a);
            b_reg   <= req.b;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

`default_nettype wire
